### sv/cbr_pkg.sv
package cbr_pkg;

    // field and datapath widths
    localparam int PT_W      = 24;
    localparam int COEF_W    = 16;
    localparam int CHUNK_W   = 32;
    localparam int NUM_CHUNK = 3;
    localparam int ACC_W     = CHUNK_W * NUM_CHUNK;
    localparam int PP_W      = CHUNK_W + 1 + PT_W;
    localparam int CFG_IDX_W = 2;

    // horner stages run 1..LAST_STAGE, stage s uses s chunks of the accumulator
    localparam logic [1:0] FIRST_STAGE = 2'd1;
    localparam logic [1:0] LAST_STAGE  = 2'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUBIC  = 2'd0,
        CFG_SQUARE = 2'd1,
        CFG_LINEAR = 2'd2,
        CFG_CONST  = 2'd3
    } cbr_cfg_idx_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       eval_start;
        logic       eval_mid;
        logic       mul;
        logic [1:0] stage;
        logic [1:0] chunk;
        logic       commit;
        logic       step;
        logic       out_load;
    } cbr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic narrow;
        logic out_free;
    } cbr_stat_t;

    // sign of a cubic value
    typedef struct packed {
        logic neg;
        logic zero;
    } cbr_sign_t;

endpackage

### sv/cubic_bisection_root_core.sv
// Bisection root finder for a cubic a*x^3 + b*x^2 + c*x + d.
// Configuration: cfg_we writes cfg_data into the coefficient chosen by cfg_index
// (0 cubic, 1 square, 2 linear, 3 constant); write only while the block is idle.
// Input channel (in_valid/in_ready) carries two interval ends, signed fixed point
// with FRAC_BITS fractional bits; they may come in either order.
// Output channel (out_valid/out_ready) carries the midpoint of the final interval,
// whose width is at most 0.001 rounded to the nearest LSB (66 LSB at 16 fractional bits).
// The cubic is evaluated exactly in a 96-bit Horner accumulator on one shared
// 33x24 multiplier, one 32-bit chunk per cycle; the sign at the lower end is
// kept across steps. An item already within tolerance goes to the output register
// with no evaluation; otherwise the lower end is evaluated once, then each bisection
// step evaluates the midpoint (at most 18 steps at 16 fractional bits).
// One item is worked on at a time; in_ready is high only while idle.
// The result sits in an output register; the next item is taken while it waits,
// and the block stalls before its own result only if that register is still full.
// Reset clears coefficients to zero, empties the output register and idles.
module cubic_bisection_root_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbr_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [cbr_pkg::PT_W-1:0]     end_one,
    input  logic signed [cbr_pkg::PT_W-1:0]     end_two,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cbr_pkg::PT_W-1:0]     root_estimate
);

    cbr_pkg::cbr_cmd_t  cmd;
    cbr_pkg::cbr_stat_t stat;

    // sequencer
    cbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // interval registers, shared multiplier and output register
    cbr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .end_one       (end_one),
        .end_two       (end_two),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .root_estimate (root_estimate)
    );

endmodule

### sv/cbr_ctrl.sv
module cbr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cbr_pkg::cbr_stat_t  stat,
    output cbr_pkg::cbr_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DRAIN,
        S_STEP,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] stage_reg, stage_next;
    logic [1:0] chunk_reg, chunk_next;
    logic       lo_done_reg, lo_done_next;
    logic       eval_mid_reg, eval_mid_next;

    // sequencing of load, evaluations, bisection steps and result transfer
    always_comb
    begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        chunk_next    = chunk_reg;
        lo_done_next  = lo_done_reg;
        eval_mid_next = eval_mid_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    lo_done_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.narrow)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    // first evaluation of an item is at the lower end
                    cmd.eval_start = 1'b1;
                    cmd.eval_mid   = lo_done_reg;
                    eval_mid_next  = lo_done_reg;
                    stage_next     = cbr_pkg::FIRST_STAGE;
                    chunk_next     = 2'd0;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul   = 1'b1;
                cmd.stage = stage_reg;
                cmd.chunk = chunk_reg;
                if (chunk_reg == stage_reg - 2'd1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    chunk_next = chunk_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                cmd.commit   = 1'b1;
                cmd.stage    = stage_reg;
                cmd.eval_mid = eval_mid_reg;
                if (stage_reg == cbr_pkg::LAST_STAGE)
                begin
                    if (eval_mid_reg)
                    begin
                        state_next = S_STEP;
                    end
                    else
                    begin
                        lo_done_next = 1'b1;
                        state_next   = S_CHECK;
                    end
                end
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    chunk_next = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            stage_reg    <= cbr_pkg::FIRST_STAGE;
            chunk_reg    <= 2'd0;
            lo_done_reg  <= 1'b0;
            eval_mid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stage_reg    <= stage_next;
            chunk_reg    <= chunk_next;
            lo_done_reg  <= lo_done_next;
            eval_mid_reg <= eval_mid_next;
        end
    end

    // chunk counter stays inside the stage
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> chunk_reg < stage_reg)
        else $error("chunk index beyond stage");

    // stage zero is never multiplied
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> stage_reg != 2'd0)
        else $error("multiply in stage zero");

    // a finished midpoint evaluation always leads to a bisection step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && stage_reg == cbr_pkg::LAST_STAGE && eval_mid_reg)
        |=> state_reg == S_STEP)
        else $error("midpoint sign dropped");

endmodule

### sv/cbr_datapath.sv
module cbr_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbr_pkg::COEF_W-1:0]          cfg_data,
    input  logic signed [cbr_pkg::PT_W-1:0]     end_one,
    input  logic signed [cbr_pkg::PT_W-1:0]     end_two,
    input  cbr_pkg::cbr_cmd_t                   cmd,
    output cbr_pkg::cbr_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cbr_pkg::PT_W-1:0]     root_estimate
);

    localparam int ACC_W   = cbr_pkg::ACC_W;
    localparam int PT_W    = cbr_pkg::PT_W;
    localparam int COEF_W  = cbr_pkg::COEF_W;
    localparam int CHUNK_W = cbr_pkg::CHUNK_W;
    localparam int PP_W    = cbr_pkg::PP_W;
    localparam int TOL_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int TOL     = (TOL_RAW < 1) ? 1 : TOL_RAW;
    localparam logic signed [PT_W:0] TOL_W = (PT_W+1)'(TOL);

    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [PT_W-1:0]   lo_reg, hi_reg, x_reg, root_reg;
    logic                     out_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg, prod_reg;
    logic signed [PP_W-1:0]   pp_reg;
    logic [1:0]               pp_chunk_reg;
    logic                     pp_valid_reg;
    cbr_pkg::cbr_sign_t       s_lo_reg, s_mid_reg;

    logic signed [PT_W:0]     width_w, mid_w;
    logic signed [PT_W-1:0]   mid;
    logic [CHUNK_W-1:0]       word;
    logic                     chunk_top;
    logic signed [CHUNK_W:0]  mul_a;
    logic signed [PP_W-1:0]   mul_full;
    logic signed [ACC_W-1:0]  pp_ext, pp_shift, sum, coef_term;
    cbr_pkg::cbr_sign_t       sum_sign;
    logic                     flip;

    // interval width and midpoint, lo <= hi always holds while busy
    assign width_w = {hi_reg[PT_W-1], hi_reg} - {lo_reg[PT_W-1], lo_reg};
    assign mid_w   = {lo_reg[PT_W-1], lo_reg} + {1'b0, width_w[PT_W:1]};
    assign mid     = mid_w[PT_W-1:0];

    assign stat.narrow   = (width_w <= TOL_W);
    assign stat.out_free = !out_valid_reg || out_ready;

    // accumulator chunk for the shared multiplier, top chunk of the stage is signed
    always_comb
    begin
        case (cmd.chunk)
            2'd0:    word = acc_reg[CHUNK_W-1:0];
            2'd1:    word = acc_reg[2*CHUNK_W-1:CHUNK_W];
            default: word = acc_reg[3*CHUNK_W-1:2*CHUNK_W];
        endcase
    end
    assign chunk_top = (cmd.chunk == cmd.stage - 2'd1);
    assign mul_a     = {chunk_top & word[CHUNK_W-1], word};
    assign mul_full  = PP_W'(mul_a) * PP_W'(x_reg);

    // partial product aligned to its chunk position
    assign pp_ext = {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};
    always_comb
    begin
        case (pp_chunk_reg)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = pp_ext <<< CHUNK_W;
            default: pp_shift = pp_ext <<< (2 * CHUNK_W);
        endcase
    end
    assign sum = pp_valid_reg ? (prod_reg + pp_shift) : prod_reg;

    // scaled coefficient added in each horner stage
    always_comb
    begin
        case (cmd.stage)
            2'd1:    coef_term = {{(ACC_W-COEF_W){coef_b_reg[COEF_W-1]}}, coef_b_reg}
                                 <<< FRAC_BITS;
            2'd2:    coef_term = {{(ACC_W-COEF_W){coef_c_reg[COEF_W-1]}}, coef_c_reg}
                                 <<< (2 * FRAC_BITS);
            default: coef_term = {{(ACC_W-COEF_W){coef_d_reg[COEF_W-1]}}, coef_d_reg}
                                 <<< (3 * FRAC_BITS);
        endcase
    end

    assign sum_sign.neg  = sum[ACC_W-1];
    assign sum_sign.zero = (sum == '0);

    // strict sign change between lower end and midpoint
    assign flip = !s_lo_reg.zero && !s_mid_reg.zero && (s_lo_reg.neg != s_mid_reg.neg);

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbr_pkg::CFG_CUBIC:  coef_a_reg <= cfg_data;
                cbr_pkg::CFG_SQUARE: coef_b_reg <= cfg_data;
                cbr_pkg::CFG_LINEAR: coef_c_reg <= cfg_data;
                cbr_pkg::CFG_CONST:  coef_d_reg <= cfg_data;
                default:             coef_a_reg <= coef_a_reg;
            endcase
        end
    end

    // interval, evaluation point and horner accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (end_two < end_one)
            begin
                lo_reg <= end_two;
                hi_reg <= end_one;
            end
            else
            begin
                lo_reg <= end_one;
                hi_reg <= end_two;
            end
        end
        else if (cmd.step)
        begin
            if (flip)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg   <= mid;
                s_lo_reg <= s_mid_reg;
            end
        end

        if (cmd.eval_start)
        begin
            x_reg   <= cmd.eval_mid ? mid : lo_reg;
            acc_reg <= {{(ACC_W-COEF_W){coef_a_reg[COEF_W-1]}}, coef_a_reg};
        end

        if (cmd.mul)
        begin
            pp_reg       <= mul_full;
            pp_chunk_reg <= cmd.chunk;
        end

        if (cmd.mul && cmd.chunk == 2'd0)
        begin
            prod_reg <= coef_term;
        end
        else
        begin
            prod_reg <= sum;
        end

        if (cmd.commit)
        begin
            if (cmd.stage == cbr_pkg::LAST_STAGE)
            begin
                if (cmd.eval_mid)
                begin
                    s_mid_reg <= sum_sign;
                end
                else
                begin
                    s_lo_reg <= sum_sign;
                end
            end
            else
            begin
                acc_reg <= sum;
            end
        end

        if (cmd.out_load)
        begin
            root_reg <= mid;
        end
    end

    // partial product valid flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pp_valid_reg <= cmd.mul;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign root_estimate = root_reg;

    // a bisection step keeps the interval ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> hi_reg >= lo_reg)
        else $error("interval ends out of order");

    // a result is only taken from a narrow interval
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.narrow)
        else $error("result from wide interval");

    // a stage commit always folds in its last partial product
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> pp_valid_reg)
        else $error("commit without partial product");

endmodule

### sim/cubic_bisection_root_core_tb.sv
module cubic_bisection_root_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PT_W = cbr_pkg::PT_W;
    localparam int COEF_W = cbr_pkg::COEF_W;
    localparam int CFG_IDX_W = cbr_pkg::CFG_IDX_W;
    localparam int FRAC_BITS = 16;
    localparam int TOL_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int TOL_LSB = (TOL_RAW < 1) ? 1 : TOL_RAW;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLDOFF_CYCLES = 1000;

    // one directed row: coefficients, interval ends, optional typed-in root
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [PT_W-1:0]   e1;
        logic signed [PT_W-1:0]   e2;
        logic                     known;
        logic signed [PT_W-1:0]   root;
    } dir_case_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = cbr_pkg::CFG_CUBIC;
    logic [COEF_W-1:0]           cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [PT_W-1:0]      end_one = '0;
    logic signed [PT_W-1:0]      end_two = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [PT_W-1:0]      root_estimate;

    // coefficients as the block should hold them
    logic signed [COEF_W-1:0]    poly_a = '0;
    logic signed [COEF_W-1:0]    poly_b = '0;
    logic signed [COEF_W-1:0]    poly_c = '0;
    logic signed [COEF_W-1:0]    poly_d = '0;

    logic signed [PT_W-1:0]      root_queue [$];
    logic signed [PT_W-1:0]      want_root;
    int                          mismatch_count = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;
    bit                          holdoff_req = 1'b0;

    dir_case_t dir_cases [0:N_DIRECTED-1] = '{
        // reset coefficients, equal ends and width at tolerance
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 1'b1, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd8388607, 24'sd8388607, 1'b1, 24'sd8388607},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -24'sd8388608, -24'sd8388608, 1'b1, -24'sd8388608},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd66, 1'b1, 24'sd33},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd66, 24'sd0, 1'b1, 24'sd33},
        // flat zero cubic: full range both orders, and one step from just over tolerance
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -24'sd8388608, 24'sd8388607, 1'b0, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd8388607, -24'sd8388608, 1'b0, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd100, 24'sd167, 1'b0, 24'sd0},
        // x - 1
        '{16'sd0, 16'sd0, 16'sd1, -16'sd1, 24'sd0, 24'sd131072, 1'b0, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd1, -16'sd1, 24'sd131072, 24'sd0, 1'b0, 24'sd0},
        // x^3 - 2
        '{16'sd1, 16'sd0, 16'sd0, -16'sd2, 24'sd0, 24'sd262144, 1'b0, 24'sd0},
        '{16'sd1, 16'sd0, 16'sd0, -16'sd2, -24'sd8388608, 24'sd8388607, 1'b0, 24'sd0},
        // f = x: zero at the lower end, then zero at the midpoint
        '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 24'sd0, 24'sd65536, 1'b0, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd1, 16'sd0, -24'sd65536, 24'sd65536, 1'b0, 24'sd0},
        // x^2 + 1 has no sign change
        '{16'sd0, 16'sd1, 16'sd0, 16'sd1, -24'sd8388608, 24'sd8388607, 1'b0, 24'sd0},
        // coefficient extremes
        '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
          -24'sd8388608, 24'sd8388607, 1'b0, 24'sd0},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
          -24'sd65536, 24'sd65536, 1'b0, 24'sd0},
        '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
          -24'sd8388608, 24'sd8388607, 1'b0, 24'sd0},
        '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
          24'sd8388607, -24'sd8388608, 1'b0, 24'sd0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
          24'sd0, 24'sd8388607, 1'b0, 24'sd0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
          -24'sd8388608, 24'sd0, 1'b0, 24'sd0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
          24'sd8388607, 24'sd8388607, 1'b1, 24'sd8388607}
    };

    cubic_bisection_root_core #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .end_one(end_one),
        .end_two(end_two),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root_estimate(root_estimate)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // exact sign of the cubic at x, scaled by 2^(3*FRAC_BITS)
    function automatic int poly_sign(input longint x);
        logic signed [127:0] xw;
        logic signed [127:0] acc;
        logic signed [127:0] bw;
        logic signed [127:0] cw;
        logic signed [127:0] dw;
        xw = 128'(x);
        acc = 128'(poly_a);
        bw = 128'(poly_b);
        cw = 128'(poly_c);
        dw = 128'(poly_d);
        acc = acc * xw + (bw <<< FRAC_BITS);
        acc = acc * xw + (cw <<< (2 * FRAC_BITS));
        acc = acc * xw + (dw <<< (3 * FRAC_BITS));
        if (acc < 0)
            return -1;
        if (acc == 0)
            return 0;
        return 1;
    endfunction

    // bisection down to the tolerance, midpoint of the last interval
    function automatic logic signed [PT_W-1:0] bisect_root(
        input logic signed [PT_W-1:0] e1,
        input logic signed [PT_W-1:0] e2
    );
        longint lo;
        longint hi;
        longint mid;
        longint t;
        lo = longint'(e1);
        hi = longint'(e2);
        if (hi < lo)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        while (hi - lo > TOL_LSB)
        begin
            mid = lo + (hi - lo) / 2;
            if (poly_sign(lo) * poly_sign(mid) < 0)
                hi = mid;
            else
                lo = mid;
        end
        mid = lo + (hi - lo) / 2;
        return mid[PT_W-1:0];
    endfunction

    // offer one interval, record its expected root on transfer
    task automatic offer_interval(
        input logic signed [PT_W-1:0] e1,
        input logic signed [PT_W-1:0] e2,
        input logic                   known,
        input logic signed [PT_W-1:0] typed_root
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        end_one <= e1;
        end_two <= e2;
        do
            @(posedge clk);
        while (!in_ready);
        if (known)
            root_queue.push_back(typed_root);
        else
            root_queue.push_back(bisect_root(e1, e2));
    endtask

    // stop offering and wait for every pending root
    task automatic drain_roots();
        in_valid <= 1'b0;
        while (root_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all four coefficients while the block is idle
    task automatic load_coefs(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b,
        input logic signed [COEF_W-1:0] c,
        input logic signed [COEF_W-1:0] d
    );
        drain_roots();
        cfg_we <= 1'b1;
        cfg_index <= cbr_pkg::CFG_CUBIC;
        cfg_data <= a;
        @(posedge clk);
        cfg_index <= cbr_pkg::CFG_SQUARE;
        cfg_data <= b;
        @(posedge clk);
        cfg_index <= cbr_pkg::CFG_LINEAR;
        cfg_data <= c;
        @(posedge clk);
        cfg_index <= cbr_pkg::CFG_CONST;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        poly_a = a;
        poly_b = b;
        poly_c = c;
        poly_d = d;
    endtask

    // random interval: full range, symmetric, narrow, or near the origin
    task automatic pick_interval(
        output logic signed [PT_W-1:0] e1,
        output logic signed [PT_W-1:0] e2
    );
        longint base;
        longint span;
        case ($urandom_range(0, 3))
            0:
            begin
                e1 = PT_W'($urandom);
                e2 = PT_W'($urandom);
            end
            1:
            begin
                span = longint'($urandom_range(1, 8388607));
                e1 = PT_W'(-span);
                e2 = PT_W'(span);
                if ($urandom_range(0, 1))
                begin
                    e1 = PT_W'(span);
                    e2 = PT_W'(-span);
                end
            end
            2:
            begin
                e1 = PT_W'($urandom);
                base = longint'(e1);
                span = longint'($urandom_range(0, 4096));
                if (base + span > 8388607)
                    e2 = PT_W'(base - span);
                else
                    e2 = PT_W'(base + span);
            end
            default:
            begin
                base = longint'($urandom_range(0, 1310720));
                e1 = PT_W'(base - 655360);
                base = longint'($urandom_range(0, 1310720));
                e2 = PT_W'(base - 655360);
            end
        endcase
    endtask

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                held = HOLDOFF_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // check each result transfer against the oldest expected root
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (root_queue.size() == 0)
            begin
                $display("%0t: unexpected root_estimate, expected none, actual %0d",
                         $time, root_estimate);
                mismatch_count++;
            end
            else
            begin
                want_root = root_queue.pop_front();
                if (root_estimate !== want_root)
                begin
                    $display("%0t: root_estimate expected %0d actual %0d",
                             $time, want_root, root_estimate);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic signed [PT_W-1:0]   e1;
        logic signed [PT_W-1:0]   e2;
        logic signed [COEF_W-1:0] ca;
        logic signed [COEF_W-1:0] cb;
        logic signed [COEF_W-1:0] cc;
        logic signed [COEF_W-1:0] cd;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (dir_cases[i].a != poly_a || dir_cases[i].b != poly_b ||
                dir_cases[i].c != poly_c || dir_cases[i].d != poly_d)
                load_coefs(dir_cases[i].a, dir_cases[i].b, dir_cases[i].c, dir_cases[i].d);
            offer_interval(dir_cases[i].e1, dir_cases[i].e2,
                           dir_cases[i].known, dir_cases[i].root);
        end

        // random phases: coefficient style and idling vary per phase
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph % 3)
                0:
                begin
                    ca = COEF_W'($signed($urandom_range(0, 16)) - 8);
                    cb = COEF_W'($signed($urandom_range(0, 16)) - 8);
                    cc = COEF_W'($signed($urandom_range(0, 16)) - 8);
                    cd = COEF_W'($signed($urandom_range(0, 16)) - 8);
                end
                1:
                begin
                    ca = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    cb = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    cc = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    cd = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
                default:
                begin
                    ca = COEF_W'($urandom);
                    cb = COEF_W'($urandom);
                    cc = COEF_W'($urandom);
                    cd = COEF_W'($urandom);
                end
            endcase
            load_coefs(ca, cb, cc, cd);

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct = 28;
                end
            endcase

            // long receiver hold-off so the block backs up into its input
            if (ph == 4)
            begin
                @(negedge clk);
                holdoff_req = 1'b1;
                @(posedge clk);
            end

            repeat (ITEMS_PER_PHASE)
            begin
                pick_interval(e1, e2);
                offer_interval(e1, e2, 1'b0, '0);
            end
        end

        drain_roots();
        repeat (250) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
